FILE: design/bmhq_pkg.sv
// shared types, constants and codes of the binary max-heap queue
package bmhq_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int CHILD_W     = COUNT_W + 1;

    typedef logic [COUNT_W-1:0]            count_t;
    typedef logic [CHILD_W-1:0]            child_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [1:0]                    status_t;

    localparam count_t CAP_COUNT = count_t'(CAPACITY);
    localparam count_t ONE_SLOT  = count_t'(1);

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // operand selection of the shared comparator
    typedef enum logic [1:0] {
        CMP_UP      = 2'd0,  // moving value > parent
        CMP_DN_SELF = 2'd1,  // left child > moving value
        CMP_DN_BEST = 2'd2   // right child > best so far
    } cmp_sel_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        value_t wdata;
        logic  re;
        addr_t raddr;
    } ram_req_t;

    typedef struct packed {
        value_t  removed_value;
        value_t  top_value;
        count_t  entry_count;
        status_t status;
    } result_t;

    // heap slots run from 1, memory addresses from 0
    function automatic addr_t slot_to_addr(input count_t slot);
        count_t s;
        s = slot - ONE_SLOT;
        return s[ADDR_W-1:0];
    endfunction

endpackage

FILE: design/binary_max_heap_queue_unit.sv
// binary max-heap priority queue: top level with output register
//
// usage:
//   s_ transfers one operation: s_operation picks insert of s_value or
//   extract of the maximum. m_ returns one result per operation: removed
//   value, new maximum, entry count and status (ok, empty, full).
// timing:
//   one operation at a time; s_ready is low while the sequencer works.
//   the heap RAM does one read and one write per cycle and the shared
//   comparator one compare per cycle; an insert climbs and an extract
//   descends the heap one level per step, and rejected operations do no
//   walk. s_ready returns in the same cycle as the result enters the
//   output register.
// reset:
//   aresetn (synchronous, active low) empties the queue and drops any
//   pending result; heap RAM contents are not cleared.
// stall:
//   while m_ready is low a result holds on m_; a further result waits in
//   the sequencer, which then takes no new operation.
module binary_max_heap_queue_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic signed [31:0]      s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [31:0]      m_removed_value,
    output logic signed [31:0]      m_top_value,
    output logic [10:0]             m_entry_count,
    output logic [1:0]              m_status
);

    // sequencer side
    bmhq_pkg::ram_req_t  ram_req;
    bmhq_pkg::value_t    ram_rdata;
    bmhq_pkg::cmp_sel_t  cmp_sel;
    bmhq_pkg::value_t    cmp_moving;
    bmhq_pkg::value_t    cmp_best;
    logic                cmp_gt;
    logic                res_valid;
    logic                res_take;
    bmhq_pkg::result_t   res;

    // output register
    logic                out_valid_reg, out_valid_next;
    bmhq_pkg::result_t   out_data_reg;

    bmhq_ram #(
        .WIDTH (bmhq_pkg::VALUE_WIDTH),
        .DEPTH (bmhq_pkg::CAPACITY)
    ) u_heap_ram (
        .clk   (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    bmhq_cmp u_cmp (
        .sel    (cmp_sel),
        .moving (cmp_moving),
        .best   (cmp_best),
        .rdata  (ram_rdata),
        .gt     (cmp_gt)
    );

    bmhq_ctrl u_ctrl (
        .clk        (aclk),
        .rstn       (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_op      (s_operation),
        .in_value   (s_value),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .cmp_sel    (cmp_sel),
        .cmp_moving (cmp_moving),
        .cmp_best   (cmp_best),
        .cmp_gt     (cmp_gt)
    );

    // the register takes a result when empty or being drained this cycle
    assign res_take = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only loads on a transfer from the sequencer
    always_ff @(posedge aclk) begin
        if (res_valid && res_take) begin
            out_data_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_removed_value = out_data_reg.removed_value;
    assign m_top_value     = out_data_reg.top_value;
    assign m_entry_count   = out_data_reg.entry_count;
    assign m_status        = out_data_reg.status;

endmodule

FILE: design/bmhq_ram.sv
// generic single-write, single-read RAM with registered read data
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/bmhq_cmp.sv
// shared signed comparator with operand selection
module bmhq_cmp (
    input  bmhq_pkg::cmp_sel_t sel,
    input  bmhq_pkg::value_t   moving,
    input  bmhq_pkg::value_t   best,
    input  bmhq_pkg::value_t   rdata,
    output logic               gt
);

    bmhq_pkg::value_t op_a;
    bmhq_pkg::value_t op_b;

    always_comb begin
        unique case (sel)
            bmhq_pkg::CMP_UP: begin
                op_a = moving;
                op_b = rdata;
            end
            bmhq_pkg::CMP_DN_SELF: begin
                op_a = rdata;
                op_b = moving;
            end
            bmhq_pkg::CMP_DN_BEST: begin
                op_a = rdata;
                op_b = best;
            end
            default: begin
                op_a = rdata;
                op_b = best;
            end
        endcase
    end

    assign gt = (op_a > op_b);

endmodule

FILE: design/bmhq_ctrl.sv
// sequencer for insert with sift-up and extract with sift-down
module bmhq_ctrl (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    input  bmhq_pkg::value_t     in_value,
    output logic                 res_valid,
    input  logic                 res_take,
    output bmhq_pkg::result_t    res,
    output bmhq_pkg::ram_req_t   ram_req,
    input  bmhq_pkg::value_t     ram_rdata,
    output bmhq_pkg::cmp_sel_t   cmp_sel,
    output bmhq_pkg::value_t     cmp_moving,
    output bmhq_pkg::value_t     cmp_best,
    input  logic                 cmp_gt
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_UP_RD   = 8'b0000_0010,
        ST_UP_CMP  = 8'b0000_0100,
        ST_EX_RD   = 8'b0000_1000,
        ST_EX_LAST = 8'b0001_0000,
        ST_DN_RDL  = 8'b0010_0000,
        ST_DN_RDR  = 8'b0100_0000,
        ST_DN_CR   = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic               done_reg, done_next;
    bmhq_pkg::count_t   cnt_reg, cnt_next;
    bmhq_pkg::count_t   pos_reg, pos_next;
    bmhq_pkg::value_t   v_reg, v_next;
    bmhq_pkg::value_t   best_reg, best_next;
    logic               best_left_reg, best_left_next;
    bmhq_pkg::value_t   removed_reg, removed_next;
    bmhq_pkg::status_t  status_reg, status_next;
    bmhq_pkg::value_t   top_reg, top_next;

    bmhq_pkg::count_t   parent;
    bmhq_pkg::child_t   left;
    bmhq_pkg::child_t   right;
    logic               l_ok;
    logic               r_ok;
    bmhq_pkg::count_t   rslot;
    logic               take_right;

    assign parent = pos_reg >> 1;
    assign left   = {1'b0, pos_reg} << 1;
    assign right  = left + bmhq_pkg::child_t'(1);
    assign l_ok   = (left <= {1'b0, cnt_reg});
    assign r_ok   = (right <= {1'b0, cnt_reg});

    assign cmp_moving = v_reg;
    assign cmp_best   = best_reg;
    assign take_right = r_ok && cmp_gt;

    always_comb begin
        state_next     = state_reg;
        done_next      = done_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        v_next         = v_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        top_next       = top_reg;
        ram_req.we     = 1'b0;
        ram_req.wdata  = v_reg;
        ram_req.re     = 1'b0;
        rslot          = parent;
        cmp_sel        = bmhq_pkg::CMP_UP;

        unique case (state_reg)
            ST_IDLE: begin
                if (done_reg) begin
                    if (res_take) begin
                        done_next = 1'b0;
                    end
                end else if (in_valid) begin
                    removed_next = '0;
                    status_next  = bmhq_pkg::STATUS_OK;
                    if (in_op == bmhq_pkg::OP_INSERT) begin
                        if (cnt_reg == bmhq_pkg::CAP_COUNT) begin
                            status_next = bmhq_pkg::STATUS_FULL;
                            done_next   = 1'b1;
                        end else begin
                            cnt_next   = cnt_reg + bmhq_pkg::ONE_SLOT;
                            pos_next   = cnt_reg + bmhq_pkg::ONE_SLOT;
                            v_next     = in_value;
                            state_next = ST_UP_RD;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = bmhq_pkg::STATUS_EMPTY;
                            done_next   = 1'b1;
                        end else begin
                            removed_next = top_reg;
                            state_next   = ST_EX_RD;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (pos_reg == bmhq_pkg::ONE_SLOT) begin
                    ram_req.we = 1'b1;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end else begin
                    ram_req.re = 1'b1;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                cmp_sel    = bmhq_pkg::CMP_UP;
                ram_req.we = 1'b1;
                if (cmp_gt) begin
                    ram_req.wdata = ram_rdata;
                    pos_next      = parent;
                    state_next    = ST_UP_RD;
                end else begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_EX_RD: begin
                ram_req.re = 1'b1;
                rslot      = cnt_reg;
                state_next = ST_EX_LAST;
            end
            ST_EX_LAST: begin
                v_next   = ram_rdata;
                cnt_next = cnt_reg - bmhq_pkg::ONE_SLOT;
                pos_next = bmhq_pkg::ONE_SLOT;
                if (cnt_reg == bmhq_pkg::ONE_SLOT) begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end else begin
                    state_next = ST_DN_RDL;
                end
            end
            ST_DN_RDL: begin
                if (!l_ok) begin
                    ram_req.we = 1'b1;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end else begin
                    ram_req.re = 1'b1;
                    rslot      = left[bmhq_pkg::COUNT_W-1:0];
                    state_next = ST_DN_RDR;
                end
            end
            ST_DN_RDR: begin
                // left child data is here, right child read goes out if there is one
                cmp_sel    = bmhq_pkg::CMP_DN_SELF;
                ram_req.re = r_ok;
                rslot      = right[bmhq_pkg::COUNT_W-1:0];
                if (cmp_gt) begin
                    best_next      = ram_rdata;
                    best_left_next = 1'b1;
                end else begin
                    best_next      = v_reg;
                    best_left_next = 1'b0;
                end
                state_next = ST_DN_CR;
            end
            ST_DN_CR: begin
                cmp_sel    = bmhq_pkg::CMP_DN_BEST;
                ram_req.we = 1'b1;
                if (take_right) begin
                    ram_req.wdata = ram_rdata;
                    pos_next      = right[bmhq_pkg::COUNT_W-1:0];
                    state_next    = ST_DN_RDL;
                end else if (best_left_reg) begin
                    ram_req.wdata = best_reg;
                    pos_next      = left[bmhq_pkg::COUNT_W-1:0];
                    state_next    = ST_DN_RDL;
                end else begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // every write lands at the current slot; track the root value
        if (ram_req.we && pos_reg == bmhq_pkg::ONE_SLOT) begin
            top_next = ram_req.wdata;
        end

        ram_req.waddr = bmhq_pkg::slot_to_addr(pos_reg);
        ram_req.raddr = bmhq_pkg::slot_to_addr(rslot);
    end

    assign in_ready  = (state_reg == ST_IDLE) && !done_reg;
    assign res_valid = (state_reg == ST_IDLE) && done_reg;

    assign res.removed_value = removed_reg;
    assign res.top_value     = (cnt_reg == '0) ? '0 : top_reg;
    assign res.entry_count   = cnt_reg;
    assign res.status        = status_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        pos_reg       <= pos_next;
        v_reg         <= v_next;
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
        top_reg       <= top_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rstn)
        cnt_reg <= bmhq_pkg::CAP_COUNT)
        else $error("entry count above capacity");

    a_read_in_heap: assert property (@(posedge clk) disable iff (!rstn)
        ram_req.re |-> (rslot != '0 && rslot <= cnt_reg))
        else $error("heap read outside occupied slots");

    a_write_state: assert property (@(posedge clk) disable iff (!rstn)
        ram_req.we |-> (state_reg == ST_UP_RD || state_reg == ST_UP_CMP ||
                        state_reg == ST_DN_RDL || state_reg == ST_DN_CR))
        else $error("heap write outside a sift step");

    a_empty_status: assert property (@(posedge clk) disable iff (!rstn)
        (res_valid && status_reg == bmhq_pkg::STATUS_EMPTY) |-> (cnt_reg == '0))
        else $error("empty status with entries held");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rstn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while first in work");

endmodule

FILE: dv/binary_max_heap_queue_unit_tb.sv
// testbench for the binary max-heap priority queue: heap predictor, tracker, random traffic
`timescale 1ns / 1ps

module binary_max_heap_queue_unit_tb;

    // generous bound: ~1200 operations, plus stalls and one long hold-off
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;   // longer than the slowest extract walk
    localparam int unsigned IDLE_PCT     = 28;
    localparam int unsigned HOLD_AFTER   = 250;  // results seen before the long hold-off
    localparam int unsigned HOLD_CYCLES  = 300;

    localparam bmhq_pkg::value_t VALUE_MAX = 32'sh7FFF_FFFF;
    localparam bmhq_pkg::value_t VALUE_MIN = 32'sh8000_0000;

    // mirror of the heap plus the results it predicts, oldest first
    class heap_queue_tracker;
        bmhq_pkg::value_t  slots [1:bmhq_pkg::CAPACITY];
        int unsigned       fill;
        bmhq_pkg::result_t pending_results [$];
        int unsigned       errors;
        int unsigned       inserts, extracts, empty_hits, full_hits, peak_fill;

        // apply one accepted operation to the mirror and queue its result
        function void apply_operation(input logic op, input bmhq_pkg::value_t val);
            bmhq_pkg::result_t r;
            bmhq_pkg::value_t  t;
            int unsigned pos, up, best, lc, rc;
            r = '0;
            r.status = bmhq_pkg::STATUS_OK;
            if (op == bmhq_pkg::OP_INSERT) begin
                inserts++;
                if (fill >= bmhq_pkg::CAPACITY) begin
                    r.status = bmhq_pkg::STATUS_FULL;
                    full_hits++;
                end else begin
                    fill++;
                    slots[fill] = val;
                    pos = fill;
                    // climb while strictly greater than the parent
                    while (pos > 1) begin
                        up = pos >> 1;
                        if (!(slots[pos] > slots[up]))
                            break;
                        t = slots[pos];
                        slots[pos] = slots[up];
                        slots[up] = t;
                        pos = up;
                    end
                end
            end else begin
                extracts++;
                if (fill == 0) begin
                    r.status = bmhq_pkg::STATUS_EMPTY;
                    empty_hits++;
                end else begin
                    r.removed_value = slots[1];
                    slots[1] = slots[fill];
                    fill--;
                    pos = 1;
                    // descend toward the larger child, left wins a tie, equal child stays
                    forever begin
                        best = pos;
                        lc = pos << 1;
                        rc = lc + 1;
                        if (lc <= fill && slots[lc] > slots[best])
                            best = lc;
                        if (rc <= fill && slots[rc] > slots[best])
                            best = rc;
                        if (best == pos)
                            break;
                        t = slots[pos];
                        slots[pos] = slots[best];
                        slots[best] = t;
                        pos = best;
                    end
                end
            end
            if (fill > peak_fill)
                peak_fill = fill;
            r.top_value   = (fill != 0) ? slots[1] : bmhq_pkg::value_t'(0);
            r.entry_count = bmhq_pkg::count_t'(fill);
            pending_results = {pending_results, r};
        endfunction

        function void compare_result(input bmhq_pkg::result_t got);
            bmhq_pkg::result_t exp;
            if (pending_results.size() == 0) begin
                $error("result with no operation outstanding: removed %0d top %0d count %0d",
                       got.removed_value, got.top_value, got.entry_count);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.removed_value !== exp.removed_value) begin
                $error("removed_value: expected %0d, actual %0d",
                       exp.removed_value, got.removed_value);
                errors++;
            end
            if (got.top_value !== exp.top_value) begin
                $error("top_value: expected %0d, actual %0d", exp.top_value, got.top_value);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d, actual %0d",
                       exp.entry_count, got.entry_count);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_operation;
    bmhq_pkg::value_t  s_value;
    logic              m_valid;
    logic              m_ready = 1'b0;
    bmhq_pkg::value_t  m_removed_value;
    bmhq_pkg::value_t  m_top_value;
    bmhq_pkg::count_t  m_entry_count;
    bmhq_pkg::status_t m_status;

    heap_queue_tracker tracker;
    bit          no_idle = 1'b0;   // both sides run back to back while set
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;

    binary_max_heap_queue_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_top_value     (m_top_value),
        .m_entry_count   (m_entry_count),
        .m_status        (m_status)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // mix of full-range, clustered (to force ties) and extreme values
    function automatic bmhq_pkg::value_t pick_value();
        case ($urandom_range(0, 3))
            0: return bmhq_pkg::value_t'($urandom_range(0, 8)) - bmhq_pkg::value_t'(4);
            1: begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return bmhq_pkg::value_t'(0);
                    default: return bmhq_pkg::value_t'(-1);
                endcase
            end
            default: return bmhq_pkg::value_t'($urandom);
        endcase
    endfunction

    // offer one operation, idling at random first; returns once the transfer is taken
    task automatic send_op(input logic op, input bmhq_pkg::value_t val);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid     <= 1'b0;
            s_operation <= 1'($urandom_range(0, 1));
            s_value     <= bmhq_pkg::value_t'($urandom);   // junk while idle
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        // s_ready read before the edge updates it, i.e. the value the block acts on
        do @(posedge aclk); while (!s_ready);
        tracker.apply_operation(op, val);
    endtask

    // receiver: random back-pressure, one long hold-off so the queue backs up into s_ready
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result monitor and run watchdog, both on the rising edge
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            tracker.compare_result(bmhq_pkg::result_t'{m_removed_value, m_top_value,
                                                       m_entry_count, m_status});
            results_seen <= results_seen + 1;
        end
    end

    initial begin
        int unsigned n;
        tracker      = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = bmhq_pkg::OP_INSERT;
        s_value      = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extract on empty, extremes, ties, drain past empty
        send_op(bmhq_pkg::OP_EXTRACT, VALUE_MAX);
        send_op(bmhq_pkg::OP_INSERT, VALUE_MAX);
        send_op(bmhq_pkg::OP_INSERT, VALUE_MIN);
        send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::value_t'(0));
        send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::value_t'(-1));
        send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::value_t'(5));
        send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::value_t'(5));
        send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::value_t'(5));
        send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::value_t'(1));
        repeat (9) send_op(bmhq_pkg::OP_EXTRACT, bmhq_pkg::value_t'($urandom));
        send_op(bmhq_pkg::OP_INSERT, VALUE_MIN);
        send_op(bmhq_pkg::OP_INSERT, VALUE_MIN);
        send_op(bmhq_pkg::OP_EXTRACT, bmhq_pkg::value_t'(0));
        send_op(bmhq_pkg::OP_EXTRACT, bmhq_pkg::value_t'(0));

        // shallow heap, extract-leaning: empty hits and short walks
        repeat (50)
            send_op(($urandom_range(0, 99) < 55) ? bmhq_pkg::OP_EXTRACT : bmhq_pkg::OP_INSERT,
                    pick_value());

        // fill to capacity with occasional extracts; a stretch runs with no idling
        n = 0;
        while (tracker.fill < bmhq_pkg::CAPACITY) begin
            no_idle = (n >= 400 && n < 600);
            send_op(($urandom_range(0, 99) < 98) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_EXTRACT,
                    pick_value());
            n++;
        end
        no_idle = 1'b0;

        // at and around full: rejected inserts and deep extracts
        repeat (40)
            send_op(($urandom_range(0, 99) < 70) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_EXTRACT,
                    pick_value());

        @(negedge aclk);
        s_valid <= 1'b0;

        // wait for every outstanding result, then a little longer for strays
        while (tracker.pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d inserts (%0d on full) and %0d extracts (%0d on empty)",
                 tracker.inserts, tracker.full_hits, tracker.extracts, tracker.empty_hits);
        $display("peak heap size %0d of %0d, %0d results compared, %0d mismatches",
                 tracker.peak_fill, bmhq_pkg::CAPACITY, results_seen, tracker.errors);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
